@@ hw/rtl/poisson_template_loglike_defines.svh @@
// Assertion macros used by the top level to check the Poisson log-likelihood block.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef POISSON_TEMPLATE_LOGLIKE_DEFINES_SVH
`define POISSON_TEMPLATE_LOGLIKE_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define PTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define PTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptl_pkg.sv @@
// Shared types and constants of the Poisson template log-likelihood block.
// No dependencies; every other RTL file imports it.
`default_nettype none

package ptl_pkg;

  localparam int COMPONENTS   = 8;
  localparam int NUM_COEF     = 8;
  localparam int CNT_W        = 16;
  localparam int TMPL_W       = 24;
  localparam int COEF_W       = 24;
  localparam int CFG_IDX_W    = 4;
  localparam int COEF_IDX_W   = 3;
  localparam int COMP_IDX_W   = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int STEP_W       = $clog2(COMPONENTS + 1);
  localparam int PROD_W       = COEF_W + TMPL_W + 1;
  localparam int ACC_W        = 52;
  localparam int MODEL_W      = 35;
  localparam int TERM_W       = 48;
  localparam int SUM_W        = 56;
  localparam int Q31_W        = 38;
  localparam int FRAC_W       = 31;
  localparam int SERIES_TERMS = 16;

  localparam logic [COEF_W-1:0] COEF_RESET   = 24'd65536;
  localparam logic [FRAC_W-1:0] LN2_Q31      = 31'd1488522236;
  localparam logic [Q31_W:0]    LN2X16_Q31   = 39'd23816355776;
  localparam logic [SUM_W-1:0]  SUM_MAX      = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN      = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TMPL_W-1:0] tmpl_0;
    logic [TMPL_W-1:0] tmpl_1;
    logic [TMPL_W-1:0] tmpl_2;
    logic [TMPL_W-1:0] tmpl_3;
    logic [TMPL_W-1:0] tmpl_4;
    logic [TMPL_W-1:0] tmpl_5;
    logic [TMPL_W-1:0] tmpl_6;
    logic [TMPL_W-1:0] tmpl_7;
    logic              last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] bin_term;
    logic signed [SUM_W-1:0]  running_sum;
    logic                     sum_done;
  } out_item_t;

  // One bin after the model has been formed, queued for the log stage.
  typedef struct packed {
    logic [MODEL_W-1:0] model;
    logic [CNT_W-1:0]   count;
    logic               last_bin;
  } job_t;

  typedef struct packed {
    logic [1:0] level;
  } fifo_status_t;

  typedef struct packed {
    logic acc_zero;
  } back_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptl_front.sv @@
// Front end: coefficient registers, input transfer and the serial model MAC.
// Depends on ptl_pkg.
`default_nettype none

module ptl_front import ptl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_W-1:0]     cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       job_valid,
  input  wire logic                  job_ready,
  output job_t                       job
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r;
  in_item_t                 item_r;
  logic [COEF_W-1:0]        coef_r [NUM_COEF];
  logic [TMPL_W-1:0]        tmpl_sel;
  logic [MODEL_W-1:0]       model_raw;

  always_comb begin
    case (step_r[COMP_IDX_W-1:0])
      3'd0:    tmpl_sel = item_r.tmpl_0;
      3'd1:    tmpl_sel = item_r.tmpl_1;
      3'd2:    tmpl_sel = item_r.tmpl_2;
      3'd3:    tmpl_sel = item_r.tmpl_3;
      3'd4:    tmpl_sel = item_r.tmpl_4;
      3'd5:    tmpl_sel = item_r.tmpl_5;
      3'd6:    tmpl_sel = item_r.tmpl_6;
      default: tmpl_sel = item_r.tmpl_7;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign job_valid = (state_r == S_PUSH);
  assign model_raw = acc_r[MODEL_W+15:16];

  // A model that truncates to zero or below is clamped to one LSB.
  always_comb begin
    job.model    = (!acc_r[ACC_W-1] && (model_raw != '0)) ? model_raw : MODEL_W'(1);
    job.count    = item_r.count;
    job.last_bin = item_r.last_bin;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MAC;
          step_nxt  = '0;
          acc_nxt   = '0;
        end
      end
      S_MAC: begin
        if (step_r != '0) begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(COMPONENTS)) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (job_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= COEF_RESET;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEF))) begin
        coef_r[cfg_index[COEF_IDX_W-1:0]] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= $signed({{(TMPL_W+1){coef_r[COEF_IDX_W'(step_r[COMP_IDX_W-1:0])][COEF_W-1]}},
                       coef_r[COEF_IDX_W'(step_r[COMP_IDX_W-1:0])]})
            * $signed({{(COEF_W+1){1'b0}}, tmpl_sel});
    if ((state_r == S_IDLE) && in_valid) begin
      item_r <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ptl_fifo.sv @@
// Two-entry job queue between the model front end and the log back end.
// Depends on ptl_pkg.
`default_nettype none

module ptl_fifo import ptl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_data,
  output logic      pop_valid,
  input  wire logic pop,
  output job_t      pop_data,
  output fifo_status_t status
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] level_r;
  logic       do_push, do_pop;

  assign push_ready   = (level_r != 2'd2);
  assign pop_valid    = (level_r != 2'd0);
  assign pop_data     = mem_r[rd_ptr_r];
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop && pop_valid;
  assign status.level = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      level_r <= level_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ptl_ln.sv @@
// Serial natural logarithm in Q.31: normalize, atanh series, one shared
// restoring divider. Depends on ptl_pkg.
`default_nettype none

module ptl_ln import ptl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [MODEL_W-1:0] x,
  output logic                    done,
  output logic [Q31_W-1:0]        result
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_DIV  = 3'd2;
  localparam logic [2:0] L_SQ   = 3'd3;
  localparam logic [2:0] L_MUL  = 3'd4;
  localparam logic [2:0] L_FIN  = 3'd5;
  localparam logic [2:0] L_DONE = 3'd6;

  localparam logic [4:0] DIV_LAST  = 5'(FRAC_W - 1);
  localparam logic [3:0] TERM_LAST = 4'(SERIES_TERMS - 1);

  logic [2:0]         state_r;
  logic [MODEL_W-1:0] xn_r;
  logic [5:0]         k_r;
  logic [4:0]         cnt_r;
  logic [3:0]         i_r;
  logic               div_z_r;
  logic [FRAC_W+1:0]  rem_r;
  logic [FRAC_W+1:0]  dsr_r;
  logic [FRAC_W-1:0]  dvd_r;
  logic [FRAC_W-1:0]  quo_r;
  logic [FRAC_W-1:0]  t_r;
  logic [FRAC_W-1:0]  zz_r;
  logic [FRAC_W:0]    s_r;
  logic [Q31_W-1:0]   res_r;

  logic [FRAC_W+2:0]   trial;
  logic                qbit;
  logic [FRAC_W+1:0]   rem_new;
  logic [FRAC_W-1:0]   q_full;
  logic [2*FRAC_W-1:0] mul_p;
  logic [FRAC_W:0]     m_norm;

  assign done   = (state_r == L_DONE);
  assign result = res_r;
  assign m_norm = xn_r[MODEL_W-1:MODEL_W-FRAC_W-1];

  always_comb begin
    trial   = {rem_r, dvd_r[FRAC_W-1]};
    qbit    = (trial >= {1'b0, dsr_r});
    rem_new = qbit ? (FRAC_W+2)'(trial - {1'b0, dsr_r}) : trial[FRAC_W+1:0];
    q_full  = {quo_r[FRAC_W-2:0], qbit};
    mul_p   = (state_r == L_SQ) ? (t_r * t_r) : (t_r * zz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      case (state_r)
        L_IDLE: if (start) state_r <= L_NORM;
        L_NORM: if (xn_r[MODEL_W-1]) state_r <= L_DIV;
        L_DIV: begin
          if (cnt_r == DIV_LAST) begin
            if (div_z_r)               state_r <= L_SQ;
            else if (i_r == TERM_LAST) state_r <= L_FIN;
            else                       state_r <= L_MUL;
          end
        end
        L_SQ:    state_r <= L_MUL;
        L_MUL:   state_r <= L_DIV;
        L_FIN:   state_r <= L_DONE;
        L_DONE:  state_r <= L_IDLE;
        default: state_r <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        xn_r <= x;
        k_r  <= 6'(MODEL_W - 1);
      end
      L_NORM: begin
        if (xn_r[MODEL_W-1]) begin
          // m in [1,2) as Q.31; the leading one is bit 31.
          rem_r   <= {2'b00, m_norm[FRAC_W-1:0]};
          dsr_r   <= (FRAC_W+2)'(m_norm) + (FRAC_W+2)'(33'h80000000);
          dvd_r   <= '0;
          cnt_r   <= '0;
          div_z_r <= 1'b1;
        end else begin
          xn_r <= {xn_r[MODEL_W-2:0], 1'b0};
          k_r  <= k_r - 6'd1;
        end
      end
      L_DIV: begin
        rem_r <= rem_new;
        dvd_r <= {dvd_r[FRAC_W-2:0], 1'b0};
        quo_r <= q_full;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          if (div_z_r) begin
            t_r <= q_full;
            s_r <= {1'b0, q_full};
            i_r <= 4'd1;
          end else begin
            s_r <= s_r + {1'b0, q_full};
            i_r <= i_r + 4'd1;
          end
        end
      end
      L_SQ: begin
        zz_r <= mul_p[2*FRAC_W-1:FRAC_W];
      end
      L_MUL: begin
        // Next series power, then divide it by the odd index 2i+1.
        t_r     <= mul_p[2*FRAC_W-1:FRAC_W];
        dvd_r   <= mul_p[2*FRAC_W-1:FRAC_W];
        rem_r   <= '0;
        dsr_r   <= {{(FRAC_W-3){1'b0}}, i_r, 1'b1};
        cnt_r   <= '0;
        div_z_r <= 1'b0;
      end
      L_FIN: begin
        res_r <= (Q31_W'(k_r) * Q31_W'(LN2_Q31)) + Q31_W'({s_r, 1'b0});
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ptl_back.sv @@
// Back end: two logarithms per bin, term arithmetic, saturating sum and the
// output register. Depends on ptl_pkg and ptl_ln.
`default_nettype none

module ptl_back import ptl_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   job_valid,
  output logic        job_pop,
  input  wire job_t   job,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data,
  output back_status_t status
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_LNM  = 3'd1;
  localparam logic [2:0] B_STN  = 3'd2;
  localparam logic [2:0] B_LNN  = 3'd3;
  localparam logic [2:0] B_DIFF = 3'd4;
  localparam logic [2:0] B_MUL  = 3'd5;
  localparam logic [2:0] B_TERM = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  logic [2:0]                state_r;
  job_t                      job_r;
  logic signed [24:0]        lm_r, ln_r;
  logic signed [26:0]        diff_r;
  logic signed [43:0]        prod_r;
  logic signed [TERM_W-1:0]  term_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic                      out_valid_r;
  out_item_t                 out_r;

  logic                      ln_start;
  logic [MODEL_W-1:0]        ln_x;
  logic                      ln_done;
  logic [Q31_W-1:0]          ln_res;
  logic [CNT_W-1:0]          n_safe;
  logic signed [Q31_W:0]     ln_v;
  logic signed [Q31_W:0]     ln_rnd;
  logic signed [SUM_W:0]     sum_w;
  logic signed [SUM_W-1:0]   sum_sat;
  logic                      load_out;

  ptl_ln u_ln (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ln_start),
    .x      (ln_x),
    .done   (ln_done),
    .result (ln_res)
  );

  assign n_safe   = (job_r.count == '0) ? CNT_W'(1) : job_r.count;
  assign ln_start = ((state_r == B_IDLE) && job_valid) || (state_r == B_STN);
  assign ln_x     = (state_r == B_IDLE) ? job.model
                                        : {{(MODEL_W-CNT_W){1'b0}}, n_safe};
  assign job_pop  = (state_r == B_IDLE) && job_valid;

  // The model logarithm is shifted from ln(M) to ln(M * 2^-16).
  // Rounding to Q.16 is a floor of (v + half LSB), ties upward.
  always_comb begin
    ln_v   = (state_r == B_LNM) ? ($signed({1'b0, ln_res}) - $signed(LN2X16_Q31))
                                : $signed({1'b0, ln_res});
    ln_rnd = (ln_v + (Q31_W+1)'(16384)) >>> 15;
  end

  always_comb begin
    sum_w = (SUM_W+1)'(acc_r) + (SUM_W+1)'(term_r);
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      sum_sat = sum_w[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_w[SUM_W-1:0];
    end
  end

  assign load_out        = (state_r == B_OUT) && (!out_valid_r || !out_stall);
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.acc_zero = (acc_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        B_IDLE:  if (job_valid) state_r <= B_LNM;
        B_LNM:   if (ln_done) state_r <= B_STN;
        B_STN:   state_r <= B_LNN;
        B_LNN:   if (ln_done) state_r <= B_DIFF;
        B_DIFF:  state_r <= B_MUL;
        B_MUL:   state_r <= B_TERM;
        B_TERM:  state_r <= B_OUT;
        B_OUT:   if (load_out) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
        acc_r       <= job_r.last_bin ? '0 : sum_sat;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) job_r <= job;
    if ((state_r == B_LNM) && ln_done) lm_r <= ln_rnd[24:0];
    if ((state_r == B_LNN) && ln_done) ln_r <= ln_rnd[24:0];
    if (state_r == B_DIFF) begin
      diff_r <= 27'(lm_r) - 27'(ln_r) + 27'sd65536;
    end
    if (state_r == B_MUL) begin
      prod_r <= $signed({{(44-CNT_W){1'b0}}, job_r.count}) * 44'(diff_r);
    end
    if (state_r == B_TERM) begin
      term_r <= TERM_W'(prod_r) - $signed({{(TERM_W-MODEL_W){1'b0}}, job_r.model});
    end
    if (load_out) begin
      out_r.bin_term    <= term_r;
      out_r.running_sum <= sum_sat;
      out_r.sum_done    <= job_r.last_bin;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/poisson_template_loglike.sv @@
// Top level of the Poisson template log-likelihood block.
// Depends on ptl_pkg, ptl_front, ptl_fifo, ptl_back and the assertion macros.
`default_nettype none
`include "poisson_template_loglike_defines.svh"

// Each input transfer carries one sky bin: an observed count and eight
// unsigned Q8.16 template values. The front end multiplies each template by its
// signed Q8.16 coefficient, one component per cycle, and sums the products
// into the model, truncated to Q.16 and clamped to one LSB when it is not
// positive. Finished models wait in a two-entry queue. The back end forms
// ln(model) and ln(count) with one serial logarithm unit whose restoring
// divider produces one quotient bit per cycle: each logarithm normalizes its
// input, then runs sixteen divisions with multiply steps between them, and
// that unit sets the throughput. The term, the saturating Q40.16 running sum
// and sum_done come out in one result transfer per bin; the sum restarts
// after a bin marked last_bin. Coefficients are to be written through the cfg
// port only while the block is idle; the block itself does not enforce this.
// Indexes 8 and above are ignored. A result waiting in the output register
// does not stop the front end from taking new bins until the queue is full.
module poisson_template_loglike import ptl_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data
);

  logic         fr_valid, fr_ready;
  job_t         fr_job;
  logic         q_valid, q_pop;
  job_t         q_job;
  fifo_status_t q_status;
  back_status_t bk_status;

  ptl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  ptl_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_job),
    .status     (q_status)
  );

  ptl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job       (q_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (bk_status)
  );

  // The queue never holds more than its two entries.
  `PTL_ASSERT_IMP(a_queue_bound, 1'b1, q_status.level != 2'd3, "job queue overfilled")
  // After a bin is taken the front end is busy with it.
  `PTL_ASSERT_NXT(a_front_busy, in_valid && !in_stall, in_stall, "front took two bins")
  // A stalled result stays valid and unchanged.
  `PTL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  // The sum restarts once the closing result of a cube is in the output register.
  `PTL_ASSERT_IMP(a_acc_cleared, $rose(out_valid) && out_data.sum_done,
                  bk_status.acc_zero, "sum not cleared after last bin")

endmodule

`default_nettype wire
